### rtl/tctb_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the three-channel timer block.
package tctb_pkg;

   localparam int DATA_W     = 16;
   localparam int CHAN_W     = 2;
   localparam int SEL_W      = 2;
   localparam int OP_W       = 2;
   localparam int CHAN_COUNT = 3;
   localparam int PRESC_W    = 3;
   localparam int STEP_W     = DATA_W + 1;
   localparam int DIV_ITERS  = STEP_W;

   localparam int MODE_RESET_TGT_BIT = 3;
   localparam int MODE_IRQ_TGT_BIT   = 4;
   localparam int MODE_IRQ_OVF_BIT   = 5;
   localparam int MODE_CLK_LSB       = 8;
   localparam int MODE_FLAG_TGT_BIT  = 11;
   localparam int MODE_FLAG_OVF_BIT  = 12;

   localparam logic [CHAN_W-1:0] LINE_CHAN = 2'd1;
   localparam logic [CHAN_W-1:0] SLOW_CHAN = 2'd2;
   localparam logic [CHAN_W-1:0] LAST_CHAN = 2'd2;

   typedef enum logic [OP_W-1:0] {
      OP_CYCLE_TICK = 2'd0,
      OP_LINE_TICK  = 2'd1,
      OP_REG_READ   = 2'd2,
      OP_REG_WRITE  = 2'd3
   } op_type;

   typedef enum logic [SEL_W-1:0] {
      SEL_COUNT  = 2'd0,
      SEL_MODE   = 2'd1,
      SEL_TARGET = 2'd2
   } reg_sel_type;

endpackage

### rtl/tctb_if.sv
`timescale 1ns / 1ps
// Request and response channel interfaces of the timer block.
interface tctb_req_if import tctb_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   op;
   logic [CHAN_W-1:0] channel;
   logic [SEL_W-1:0]  reg_select;
   logic [DATA_W-1:0] write_data;
   logic [DATA_W-1:0] cycles;

   modport source (output valid, op, channel, reg_select, write_data, cycles, input ready);
   modport sink (input valid, op, channel, reg_select, write_data, cycles, output ready);
endinterface

interface tctb_rsp_if import tctb_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [DATA_W-1:0]     read_data;
   logic [CHAN_COUNT-1:0] irq_pulses;

   modport source (output valid, read_data, irq_pulses, input ready);
   modport sink (input valid, read_data, irq_pulses, output ready);
endinterface

### rtl/three_channel_timer_block_top.sv
`timescale 1ns / 1ps
// Three 16-bit timer channels with a shared sequencer and iterative remainder unit.
//
// Usage:
//   req_bus carries one operation per transfer: cycle tick, display-line tick,
//   register read or register write. rsp_bus returns exactly one transfer per
//   request: read_data for reads, irq_pulses for ticks, zeros otherwise.
//   req_bus.ready is high only while the sequencer is idle; one request is
//   worked on at a time.
// Sequence (request transfer to response valid):
//   register read/write: ST_REG, then ST_DONE.
//   tick: ST_LOAD and ST_EVAL for each channel in turn, plus ST_DIV for each channel
//   that wraps in reset-on-target mode (the remainder by the target runs through one
//   restoring subtract-and-compare unit, one quotient bit per cycle),
//   then ST_DONE.
// Requests do not overlap: the next one is taken only after the last has left ST_DONE.
// A finished response sits in an output register; a new request is taken
// while it waits, and the sequencer holds the next response until rsp_bus
// ready frees the register.
// Reset: synchronous, active high; clears all counters, modes, targets,
// prescale remainders and flags, and empties the output register.
module three_channel_timer_block_top import tctb_pkg::*; (
   input logic        clock,
   input logic        reset,
   tctb_req_if.sink   req_bus,
   tctb_rsp_if.source rsp_bus
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_REG, ST_LOAD, ST_EVAL, ST_DIV, ST_DONE
   } state_type;

   state_type             state_ff;
   logic [OP_W-1:0]       op_ff;
   logic [CHAN_W-1:0]     ch_ff;
   logic [SEL_W-1:0]      sel_ff;
   logic [DATA_W-1:0]     wdata_ff;
   logic [DATA_W-1:0]     cycles_ff;

   logic [DATA_W-1:0]     count_ff  [CHAN_COUNT];
   logic [DATA_W-1:0]     mode_ff   [CHAN_COUNT];
   logic [DATA_W-1:0]     target_ff [CHAN_COUNT];
   logic [PRESC_W-1:0]    presc_ff  [CHAN_COUNT];
   logic [CHAN_COUNT-1:0] tflag_ff;
   logic [CHAN_COUNT-1:0] oflag_ff;

   logic [STEP_W-1:0]     steps_ff;
   logic [STEP_W-1:0]     first_ff;
   logic [STEP_W-1:0]     dist_ff;
   logic [STEP_W-1:0]     period_ff;
   logic [STEP_W-1:0]     dvd_ff;
   logic [DATA_W-1:0]     rem_ff;
   logic [4:0]            div_cnt_ff;
   logic [DATA_W-1:0]     rdata_ff;
   logic [CHAN_COUNT-1:0] irq_ff;

   logic                  rsp_valid_ff;
   logic [DATA_W-1:0]     rsp_rdata_ff;
   logic [CHAN_COUNT-1:0] rsp_irq_ff;

   logic [DATA_W-1:0]     cur_cnt, cur_mode, cur_tgt;
   logic [PRESC_W-1:0]    cur_presc;
   logic [1:0]            clk_sel;
   logic                  line_clk, slow_div, chan_valid;
   logic [STEP_W-1:0]     presc_total_in;
   logic [STEP_W-1:0]     steps_in;
   logic [PRESC_W-1:0]    presc_in;
   logic [STEP_W-1:0]     first_in;
   logic [DATA_W-1:0]     dist16;
   logic [STEP_W-1:0]     dist_in;
   logic [STEP_W:0]       total_in;
   logic [STEP_W-1:0]     rest_in;
   logic [STEP_W-1:0]     div_shift;
   logic                  div_ge;
   logic [DATA_W-1:0]     rem_in;
   logic                  req_fire;
   logic                  out_free;

   assign req_bus.ready     = (state_ff == ST_IDLE);
   assign req_fire          = req_bus.valid && req_bus.ready;
   assign out_free          = !rsp_valid_ff || rsp_bus.ready;
   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.read_data = rsp_rdata_ff;
   assign rsp_bus.irq_pulses = rsp_irq_ff;

   always_comb begin
      chan_valid = (ch_ff <= LAST_CHAN);
      cur_cnt    = count_ff[ch_ff];
      cur_mode   = mode_ff[ch_ff];
      cur_tgt    = target_ff[ch_ff];
      cur_presc  = presc_ff[ch_ff];
      clk_sel    = cur_mode[MODE_CLK_LSB +: 2];
      line_clk   = (ch_ff == LINE_CHAN) && clk_sel[0];
      slow_div   = (ch_ff == SLOW_CHAN) && clk_sel[1];

      presc_total_in = {{(STEP_W-PRESC_W){1'b0}}, cur_presc} + {1'b0, cycles_ff};
      if (op_ff == OP_CYCLE_TICK) begin
         if (line_clk) begin
            steps_in = '0;
            presc_in = cur_presc;
         end else if (slow_div) begin
            steps_in = presc_total_in >> PRESC_W;
            presc_in = presc_total_in[PRESC_W-1:0];
         end else begin
            steps_in = presc_total_in;
            presc_in = '0;
         end
      end else begin
         steps_in = line_clk ? STEP_W'(1) : '0;
         presc_in = cur_presc;
      end

      if (cur_tgt == '0)
         first_in = STEP_W'(1 << DATA_W) - {1'b0, cur_cnt};
      else if (cur_cnt < cur_tgt)
         first_in = {1'b0, cur_tgt - cur_cnt};
      else
         first_in = STEP_W'(1 << DATA_W) - {1'b0, cur_cnt} + {1'b0, cur_tgt};

      dist16  = cur_tgt - cur_cnt;
      dist_in = (dist16 == '0) ? STEP_W'(1 << DATA_W) : {1'b0, dist16};

      total_in = {2'b00, cur_cnt} + {1'b0, steps_ff};
      rest_in  = steps_ff - first_ff;

      div_shift = {rem_ff, dvd_ff[STEP_W-1]};
      div_ge    = (div_shift >= period_ff);
      rem_in    = div_ge ? DATA_W'(div_shift - period_ff) : div_shift[DATA_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         tflag_ff     <= '0;
         oflag_ff     <= '0;
         for (int i = 0; i < CHAN_COUNT; i++) begin
            count_ff[i]  <= '0;
            mode_ff[i]   <= '0;
            target_ff[i] <= '0;
            presc_ff[i]  <= '0;
         end
      end else begin
         if (state_ff == ST_DONE && out_free)
            rsp_valid_ff <= 1'b1;
         else if (rsp_bus.ready)
            rsp_valid_ff <= 1'b0;

         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  op_ff     <= req_bus.op;
                  sel_ff    <= req_bus.reg_select;
                  wdata_ff  <= req_bus.write_data;
                  cycles_ff <= req_bus.cycles;
                  rdata_ff  <= '0;
                  irq_ff    <= '0;
                  if (req_bus.op == OP_REG_READ || req_bus.op == OP_REG_WRITE) begin
                     ch_ff    <= req_bus.channel;
                     state_ff <= ST_REG;
                  end else begin
                     ch_ff    <= '0;
                     state_ff <= ST_LOAD;
                  end
               end
            end

            ST_REG: begin
               if (chan_valid) begin
                  if (op_ff == OP_REG_READ) begin
                     unique case (sel_ff)
                        SEL_COUNT:  rdata_ff <= cur_cnt;
                        SEL_MODE: begin
                           rdata_ff <= cur_mode
                              | (DATA_W'(tflag_ff[ch_ff]) << MODE_FLAG_TGT_BIT)
                              | (DATA_W'(oflag_ff[ch_ff]) << MODE_FLAG_OVF_BIT);
                           tflag_ff[ch_ff] <= 1'b0;
                           oflag_ff[ch_ff] <= 1'b0;
                        end
                        SEL_TARGET: rdata_ff <= cur_tgt;
                        default:    rdata_ff <= '0;
                     endcase
                  end else begin
                     unique case (sel_ff)
                        SEL_COUNT:  count_ff[ch_ff] <= wdata_ff;
                        SEL_MODE: begin
                           mode_ff[ch_ff]  <= wdata_ff;
                           count_ff[ch_ff] <= '0;
                           presc_ff[ch_ff] <= '0;
                           tflag_ff[ch_ff] <= 1'b0;
                           oflag_ff[ch_ff] <= 1'b0;
                        end
                        SEL_TARGET: target_ff[ch_ff] <= wdata_ff;
                        default: ;
                     endcase
                  end
               end
               state_ff <= ST_DONE;
            end

            ST_LOAD: begin
               steps_ff        <= steps_in;
               first_ff        <= first_in;
               dist_ff         <= dist_in;
               presc_ff[ch_ff] <= presc_in;
               state_ff        <= ST_EVAL;
            end

            ST_EVAL: begin
               if (steps_ff != '0 && cur_mode[MODE_RESET_TGT_BIT] && steps_ff >= first_ff) begin
                  tflag_ff[ch_ff] <= 1'b1;
                  if (cur_mode[MODE_IRQ_TGT_BIT])
                     irq_ff[ch_ff] <= 1'b1;
                  dvd_ff     <= rest_in;
                  period_ff  <= (cur_tgt == '0) ? STEP_W'(1 << DATA_W) : {1'b0, cur_tgt};
                  rem_ff     <= '0;
                  div_cnt_ff <= '0;
                  state_ff   <= ST_DIV;
               end else begin
                  if (steps_ff != '0) begin
                     count_ff[ch_ff] <= total_in[DATA_W-1:0];
                     if (!cur_mode[MODE_RESET_TGT_BIT]) begin
                        if (steps_ff >= dist_ff)
                           tflag_ff[ch_ff] <= 1'b1;
                        if (total_in[STEP_W:DATA_W] != '0)
                           oflag_ff[ch_ff] <= 1'b1;
                        if ((steps_ff >= dist_ff && cur_mode[MODE_IRQ_TGT_BIT])
                            || (total_in[STEP_W:DATA_W] != '0 && cur_mode[MODE_IRQ_OVF_BIT]))
                           irq_ff[ch_ff] <= 1'b1;
                     end
                  end
                  if (ch_ff == LAST_CHAN) begin
                     state_ff <= ST_DONE;
                  end else begin
                     ch_ff    <= ch_ff + 2'd1;
                     state_ff <= ST_LOAD;
                  end
               end
            end

            ST_DIV: begin
               rem_ff     <= rem_in;
               dvd_ff     <= dvd_ff << 1;
               div_cnt_ff <= div_cnt_ff + 5'd1;
               if (div_cnt_ff == 5'(DIV_ITERS - 1)) begin
                  count_ff[ch_ff] <= rem_in;
                  if (ch_ff == LAST_CHAN) begin
                     state_ff <= ST_DONE;
                  end else begin
                     ch_ff    <= ch_ff + 2'd1;
                     state_ff <= ST_LOAD;
                  end
               end
            end

            ST_DONE: begin
               if (out_free) begin
                  rsp_rdata_ff <= rdata_ff;
                  rsp_irq_ff   <= irq_ff;
                  state_ff     <= ST_IDLE;
               end
            end

            default: state_ff <= ST_IDLE;
         endcase
      end
   end

`ifndef ASSERT_OFF
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_bus.ready)
      else $error("request taken while sequencer busy");

   a_rem_below_period: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> ({1'b0, rem_ff} < period_ff))
      else $error("partial remainder not below period");

   a_div_count_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (div_cnt_ff < 5'(DIV_ITERS)))
      else $error("remainder iteration count out of range");

   a_tick_channel_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD || state_ff == ST_EVAL || state_ff == ST_DIV) |-> chan_valid)
      else $error("tick sequencer on invalid channel");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside completion");
`endif

endmodule
